[rtl/core/socks5_udp_header_stripper_defines.svh]
// ---------------------------------------------------------------------------
// socks5_udp_header_stripper_defines
// Assertion macros for the SOCKS5 UDP header stripper.
// ---------------------------------------------------------------------------
`ifndef SOCKS5_UDP_HEADER_STRIPPER_DEFINES_SVH
`define SOCKS5_UDP_HEADER_STRIPPER_DEFINES_SVH

`ifndef SYNTHESIS
`define S5UHS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define S5UHS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define S5UHS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define S5UHS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

[rtl/core/s5uhs_pkg.sv]
// ---------------------------------------------------------------------------
// s5uhs_pkg
// Types and constants shared by the SOCKS5 UDP header stripper.
// ---------------------------------------------------------------------------
package s5uhs_pkg;

   localparam int unsigned HDR_POS_W = 9;

   localparam logic [HDR_POS_W-1:0] POS_ATYP        = 9'd3;
   localparam logic [HDR_POS_W-1:0] POS_ALEN        = 9'd4;
   localparam logic [HDR_POS_W-1:0] LEN_IPV4        = 9'd10;
   localparam logic [HDR_POS_W-1:0] LEN_IPV6        = 9'd22;
   localparam logic [HDR_POS_W-1:0] LEN_DOMAIN_BASE = 9'd7;

   localparam logic [7:0] ATYP_IPV4   = 8'd1;
   localparam logic [7:0] ATYP_DOMAIN = 8'd3;
   localparam logic [7:0] ATYP_IPV6   = 8'd4;

   typedef enum logic [1:0] {
      STATUS_PAYLOAD = 2'd0,
      STATUS_DROPPED = 2'd1,
      STATUS_EMPTY   = 2'd2
   } status_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       last;
      status_type status;
   } result_type;

endpackage

[rtl/core/s5uhs_parser.sv]
// ---------------------------------------------------------------------------
// s5uhs_parser
// Per-datagram header walker: tracks header position and length, strips
// nested headers and produces at most one result per accepted byte.
// ---------------------------------------------------------------------------
module s5uhs_parser
   import s5uhs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       data_byte,
   input  logic             last_byte,
   input  logic [1:0]       strip_count,
   output result_type       result
);

   logic [1:0]           headers_left_ff, headers_left_in;
   logic [HDR_POS_W-1:0] header_pos_ff, header_pos_in;
   logic [HDR_POS_W-1:0] header_len_ff, header_len_in;
   logic                 bad_header_ff, bad_header_in;
   logic                 in_payload_ff, in_payload_in;
   logic                 mid_datagram_ff, mid_datagram_in;

   always_comb begin
      headers_left_in = headers_left_ff;
      header_pos_in   = header_pos_ff;
      header_len_in   = header_len_ff;
      bad_header_in   = bad_header_ff;
      in_payload_in   = in_payload_ff;
      result          = '{valid: 1'b0, data: 8'd0, last: 1'b0, status: STATUS_PAYLOAD};

      if (!mid_datagram_ff) begin
         headers_left_in = strip_count;
         header_pos_in   = '0;
         header_len_in   = '0;
         bad_header_in   = 1'b0;
         in_payload_in   = (strip_count == 2'd0);
      end

      if (bad_header_in) begin
         // swallow to end of datagram
      end else if (in_payload_in) begin
         result.valid = 1'b1;
         result.data  = data_byte;
         result.last  = last_byte;
      end else begin
         if (header_pos_in == POS_ATYP) begin
            priority if (data_byte == ATYP_IPV4) begin
               header_len_in = LEN_IPV4;
            end else if (data_byte == ATYP_IPV6) begin
               header_len_in = LEN_IPV6;
            end else if (data_byte == ATYP_DOMAIN) begin
               header_len_in = '0;
            end else begin
               bad_header_in = 1'b1;
            end
         end else if (header_pos_in == POS_ALEN && header_len_in == '0) begin
            header_len_in = LEN_DOMAIN_BASE + HDR_POS_W'(data_byte);
         end
         header_pos_in = header_pos_in + 9'd1;
         if (!bad_header_in && header_len_in != '0 && header_pos_in == header_len_in) begin
            headers_left_in = headers_left_in - 2'd1;
            header_pos_in   = '0;
            header_len_in   = '0;
            if (headers_left_in == 2'd0) begin
               in_payload_in = 1'b1;
            end
         end
      end

      if (last_byte && !result.valid) begin
         result.valid  = 1'b1;
         result.last   = 1'b1;
         result.status = (bad_header_in || !in_payload_in) ? STATUS_DROPPED : STATUS_EMPTY;
      end

      mid_datagram_in = !last_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         headers_left_ff <= '0;
         header_pos_ff   <= '0;
         header_len_ff   <= '0;
         bad_header_ff   <= 1'b0;
         in_payload_ff   <= 1'b0;
         mid_datagram_ff <= 1'b0;
      end else if (accept) begin
         headers_left_ff <= headers_left_in;
         header_pos_ff   <= header_pos_in;
         header_len_ff   <= header_len_in;
         bad_header_ff   <= bad_header_in;
         in_payload_ff   <= in_payload_in;
         mid_datagram_ff <= mid_datagram_in;
      end
   end

endmodule

[rtl/core/socks5_udp_header_stripper.sv]
// ---------------------------------------------------------------------------
// socks5_udp_header_stripper
// Strips hop_count - 1 nested SOCKS5 UDP headers from a byte stream, with hop_count clamped to 1..MAX_HOPS.
// An accepted req word's rsp word, if it has one, is registered and appears in the cycle after acceptance.
// Throughput: 1 word per cycle while rsp_tready is high; the output register refills as it drains.
// Reset: synchronous; hop_count returns to 1, datagram state and rsp_tvalid clear.
// ---------------------------------------------------------------------------
`include "socks5_udp_header_stripper_defines.svh"

module socks5_udp_header_stripper
   import s5uhs_pkg::*;
#(
   parameter int unsigned MAX_HOPS = 3
)(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [1:0] csr_wdata,     // hop_count
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,     // [7:0] data_byte
   input  logic       req_tlast,     // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,     // [7:0] out_byte
   output logic       rsp_tlast,     // out_last
   output logic [1:0] rsp_tuser      // [1:0] status
);

   localparam logic [1:0] MAX_HOPS_C = 2'(MAX_HOPS);

   logic [1:0] hop_count_ff;
   logic [1:0] hop_sat;
   logic [1:0] strip_count;
   logic       req_accept;
   result_type result;

   logic       rsp_valid_ff;
   logic [7:0] rsp_data_ff;
   logic       rsp_last_ff;
   status_type rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hop_count_ff <= 2'd1;
      end else if (csr_we) begin
         hop_count_ff <= csr_wdata;
      end
   end

   always_comb begin
      hop_sat = hop_count_ff;
      if (hop_sat == 2'd0) begin
         hop_sat = 2'd1;
      end
      if (hop_sat > MAX_HOPS_C) begin
         hop_sat = MAX_HOPS_C;
      end
      strip_count = hop_sat - 2'd1;
   end

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   s5uhs_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .data_byte   (req_tdata),
      .last_byte   (req_tlast),
      .strip_count (strip_count),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= result.valid;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && result.valid) begin
         rsp_data_ff   <= result.data;
         rsp_last_ff   <= result.last;
         rsp_status_ff <= result.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;

   `S5UHS_ASSERT_NEXT(a_last_gives_word, clock, reset, req_accept && req_tlast, rsp_tvalid, "no word for last byte")
   `S5UHS_ASSERT_IMP(a_drop_is_final, clock, reset, rsp_tvalid && rsp_tuser != STATUS_PAYLOAD, rsp_tlast && rsp_tdata == 8'd0, "status word not final or not zero")
   `S5UHS_ASSERT_IMP(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready, "stalled with empty output")

endmodule
